/* rtl/core/kmm_pkg.sv */
`timescale 1ns / 1ps
// kmm_pkg: types, constants and helper functions of the keyed min/max aggregator
// used by the parser, queue, table and top files; depends on nothing
package kmm_pkg;

	localparam int HASH_BITS   = 10;
	localparam int NUM_ENTRIES = 1 << HASH_BITS;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	typedef logic [HASH_BITS-1:0] hash_t;
	typedef logic signed [17:0]   tenths_t;
	typedef logic [13:0]          accum_t;
	typedef logic [16:0]          wide_acc_t;
	typedef logic [FIFO_AW-1:0]   fifo_ptr_t;
	typedef logic [FIFO_AW:0]     fifo_cnt_t;

	localparam tenths_t EMPTY_MIN = tenths_t'(100000);
	localparam tenths_t EMPTY_MAX = tenths_t'(-100000);
	localparam accum_t  INT_LIMIT = accum_t'(9999);

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [7:0] DELIM_RESET = 8'd59;
	localparam logic [9:0] SEED_RESET  = 10'd1009;

	localparam logic REG_FIELD_DELIM = 1'b0;
	localparam logic REG_HASH_SEED   = 1'b1;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		PH_START,
		PH_NAME,
		PH_SIGN,
		PH_INT,
		PH_FRAC,
		PH_SKIP
	} phase_t;

	typedef enum logic {
		CMD_UPDATE,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		hash_t     idx;
		tenths_t   value;
	} cmd_t;

	typedef struct packed {
		logic    used;
		tenths_t min_v;
		tenths_t max_v;
	} entry_t;

	typedef enum logic [1:0] {
		TS_CLEAR,
		TS_IDLE,
		TS_EXEC
	} tbl_state_t;

	// hash * 33 xor sign-extended byte, kept to HASH_BITS
	function automatic hash_t fold_hash(input hash_t h, input logic [7:0] b);
		logic [31:0] hx;
		logic [31:0] ext;
		hx  = 32'(h);
		ext = {{24{b[7]}}, b};
		return hash_t'(((hx << 5) + hx) ^ ext);
	endfunction

	function automatic logic [3:0] digit_of(input logic [7:0] b);
		logic [7:0] d;
		d = b - CHAR_ZERO;
		if (b >= CHAR_ZERO && b <= CHAR_NINE)
			return d[3:0];
		return 4'd0;
	endfunction

	// acc * 10 + digit
	function automatic wide_acc_t times_ten_add(input accum_t acc, input logic [7:0] b);
		wide_acc_t a;
		a = wide_acc_t'(acc);
		return (a << 3) + (a << 1) + wide_acc_t'(digit_of(b));
	endfunction

endpackage

/* rtl/core/kmm_if.sv */
`timescale 1ns / 1ps
// kmm_in_if / kmm_out_if: valid-ready channels for input items and result items
// no dependencies
interface kmm_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;
	logic [9:0] read_index;

	modport source (output valid, output opcode, output data_byte, output read_index,
		input ready);
	modport sink (input valid, input opcode, input data_byte, input read_index,
		output ready);
endinterface

interface kmm_out_if;
	logic               valid;
	logic               ready;
	logic               entry_used;
	logic signed [17:0] min_tenths;
	logic signed [17:0] max_tenths;

	modport source (output valid, output entry_used, output min_tenths, output max_tenths,
		input ready);
	modport sink (input valid, input entry_used, input min_tenths, input max_tenths,
		output ready);
endinterface

/* rtl/core/kmm_parser.sv */
`timescale 1ns / 1ps
// kmm_parser: front end; accepts beats, parses record text, holds the config registers
// and emits update / read commands; depends on kmm_pkg and kmm_in_if
module kmm_parser (
	input  logic            clk,
	input  logic            arst_n,
	kmm_in_if.sink          item,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [9:0]      cfg_data,
	input  logic            fifo_full,
	input  logic            clear_busy,
	output logic            cmd_push,
	output kmm_pkg::cmd_t   cmd
);

	kmm_pkg::phase_t  phase_q, phase_d;
	kmm_pkg::hash_t   hash_q, hash_d;
	logic             neg_q, neg_d;
	kmm_pkg::accum_t  acc_q, acc_d;
	logic [7:0]       delim_q;
	logic [9:0]       seed_q;

	logic                accept;
	logic [7:0]          b;
	kmm_pkg::hash_t      seed_h;
	kmm_pkg::wide_acc_t  acc_next;
	kmm_pkg::accum_t     acc_sat;
	kmm_pkg::tenths_t    mag;

	assign item.ready = !fifo_full && !clear_busy;
	assign accept     = item.valid && item.ready;
	assign b          = item.data_byte;
	assign seed_h     = kmm_pkg::hash_t'(seed_q);
	assign acc_next   = kmm_pkg::times_ten_add(acc_q, b);
	assign acc_sat    = (acc_next > kmm_pkg::wide_acc_t'(kmm_pkg::INT_LIMIT)) ?
		kmm_pkg::INT_LIMIT : kmm_pkg::accum_t'(acc_next);
	assign mag        = kmm_pkg::tenths_t'(acc_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= kmm_pkg::DELIM_RESET;
			seed_q  <= kmm_pkg::SEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmm_pkg::REG_FIELD_DELIM: delim_q <= cfg_data[7:0];
				kmm_pkg::REG_HASH_SEED:   seed_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kmm_pkg::PH_START;
			hash_q  <= kmm_pkg::hash_t'(kmm_pkg::SEED_RESET);
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			hash_q  <= hash_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		hash_d    = hash_q;
		neg_d     = neg_q;
		acc_d     = acc_q;
		cmd_push  = 1'b0;
		cmd.kind  = kmm_pkg::CMD_READ;
		cmd.idx   = kmm_pkg::hash_t'(item.read_index);
		cmd.value = neg_q ? -mag : mag;
		if (accept) begin
			if (item.opcode == kmm_pkg::OP_READ) begin
				cmd_push = 1'b1;
			end else begin
				unique case (phase_q)
					kmm_pkg::PH_NAME: begin
						if (b == delim_q)
							phase_d = kmm_pkg::PH_SIGN;
						else
							hash_d = kmm_pkg::fold_hash(hash_q, b);
					end
					kmm_pkg::PH_SIGN: begin
						neg_d = 1'b0;
						acc_d = '0;
						if (b == kmm_pkg::CHAR_MINUS) begin
							neg_d   = 1'b1;
							phase_d = kmm_pkg::PH_INT;
						end else if (b == kmm_pkg::CHAR_DOT) begin
							phase_d = kmm_pkg::PH_FRAC;
						end else begin
							acc_d   = kmm_pkg::accum_t'(kmm_pkg::digit_of(b));
							phase_d = kmm_pkg::PH_INT;
						end
					end
					kmm_pkg::PH_INT: begin
						if (b == kmm_pkg::CHAR_DOT)
							phase_d = kmm_pkg::PH_FRAC;
						else
							acc_d = acc_sat;
					end
					kmm_pkg::PH_FRAC: begin
						cmd_push = 1'b1;
						cmd.kind = kmm_pkg::CMD_UPDATE;
						cmd.idx  = hash_q;
						phase_d  = kmm_pkg::PH_SKIP;
					end
					kmm_pkg::PH_SKIP: begin
						neg_d   = 1'b0;
						acc_d   = '0;
						hash_d  = seed_h;
						phase_d = kmm_pkg::PH_START;
					end
					default: begin
						neg_d = 1'b0;
						acc_d = '0;
						if (b == delim_q) begin
							hash_d  = seed_h;
							phase_d = kmm_pkg::PH_SIGN;
						end else begin
							hash_d  = kmm_pkg::fold_hash(seed_h, b);
							phase_d = kmm_pkg::PH_NAME;
						end
					end
				endcase
			end
		end
	end

endmodule

/* rtl/core/kmm_cmd_fifo.sv */
`timescale 1ns / 1ps
// kmm_cmd_fifo: short command queue between the parser and the table engine
// depends on kmm_pkg
module kmm_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kmm_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output kmm_pkg::cmd_t   head_cmd,
	output logic            empty,
	output logic            full
);

	kmm_pkg::cmd_t      slots_q [kmm_pkg::FIFO_DEPTH];
	kmm_pkg::fifo_ptr_t wr_ptr_q, rd_ptr_q;
	kmm_pkg::fifo_cnt_t count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == kmm_pkg::fifo_cnt_t'(kmm_pkg::FIFO_DEPTH));
	assign head_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/core/kmm_table.sv */
`timescale 1ns / 1ps
// kmm_table: back end; holds the entry table, clears it after reset, applies
// min/max updates and answers reads; depends on kmm_pkg and kmm_out_if
module kmm_table (
	input  logic            clk,
	input  logic            arst_n,
	input  kmm_pkg::cmd_t   head_cmd,
	input  logic            fifo_empty,
	output logic            pop,
	output logic            clear_busy,
	kmm_out_if.source       result
);

	kmm_pkg::entry_t     mem [kmm_pkg::NUM_ENTRIES];
	kmm_pkg::entry_t     rdata_q;
	kmm_pkg::cmd_t       cmd_q;
	kmm_pkg::tbl_state_t state_q, state_d;
	kmm_pkg::hash_t      clr_cnt_q;

	logic            out_valid_q;
	logic            out_used_q;
	kmm_pkg::tenths_t out_min_q, out_max_q;

	logic            we;
	kmm_pkg::hash_t  waddr;
	kmm_pkg::entry_t wdata;
	logic            load_out;
	kmm_pkg::entry_t upd;

	assign clear_busy = (state_q == kmm_pkg::TS_CLEAR);

	always_comb begin
		upd.used  = 1'b1;
		upd.min_v = (cmd_q.value < rdata_q.min_v) ? cmd_q.value : rdata_q.min_v;
		upd.max_v = (cmd_q.value > rdata_q.max_v) ? cmd_q.value : rdata_q.max_v;
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		we       = 1'b0;
		waddr    = cmd_q.idx;
		wdata    = upd;
		load_out = 1'b0;
		unique case (state_q)
			kmm_pkg::TS_CLEAR: begin
				we          = 1'b1;
				waddr       = clr_cnt_q;
				wdata.used  = 1'b0;
				wdata.min_v = kmm_pkg::EMPTY_MIN;
				wdata.max_v = kmm_pkg::EMPTY_MAX;
				if (clr_cnt_q == kmm_pkg::hash_t'(kmm_pkg::NUM_ENTRIES - 1))
					state_d = kmm_pkg::TS_IDLE;
			end
			kmm_pkg::TS_IDLE: begin
				if (!fifo_empty) begin
					pop     = 1'b1;
					state_d = kmm_pkg::TS_EXEC;
				end
			end
			kmm_pkg::TS_EXEC: begin
				if (cmd_q.kind == kmm_pkg::CMD_UPDATE) begin
					we      = 1'b1;
					state_d = kmm_pkg::TS_IDLE;
				end else if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = kmm_pkg::TS_IDLE;
				end
			end
			default: state_d = kmm_pkg::TS_IDLE;
		endcase
	end

	// table storage
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (pop)
			rdata_q <= mem[head_cmd.idx];
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head_cmd;
		if (load_out) begin
			out_used_q <= rdata_q.used;
			out_min_q  <= rdata_q.min_v;
			out_max_q  <= rdata_q.max_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kmm_pkg::TS_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kmm_pkg::TS_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.entry_used = out_used_q;
	assign result.min_tenths = out_min_q;
	assign result.max_tenths = out_max_q;

endmodule

/* rtl/core/keyed_min_max_record_aggregator_top.sv */
`timescale 1ns / 1ps
// keyed_min_max_record_aggregator_top: parser front end, command queue and table back end
// depends on kmm_pkg, kmm_if, kmm_parser, kmm_cmd_fifo, kmm_table
// throughput: one beat per cycle at the input while the queue has room and no clear runs; the table
// engine takes each command as a table read, then a write or result load (held while a result waits)
// a read result is registered; its command passes the queue, the table read and the result load
// reset: after arst_n releases, a clearing pass over all 1024 entries (one table entry a cycle)
// runs with ready low; config registers take 59 and 1009 and are writable during it
module keyed_min_max_record_aggregator_top (
	input  logic        clk,
	input  logic        arst_n,
	kmm_in_if.sink      item_in,
	kmm_out_if.source   result_out,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data
);

	logic          cmd_push;
	kmm_pkg::cmd_t cmd;
	kmm_pkg::cmd_t head_cmd;
	logic          fifo_empty;
	logic          fifo_full;
	logic          pop;
	logic          clear_busy;

	kmm_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fifo_full  (fifo_full),
		.clear_busy (clear_busy),
		.cmd_push   (cmd_push),
		.cmd        (cmd)
	);

	kmm_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (fifo_empty),
		.full     (fifo_full)
	);

	kmm_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.clear_busy (clear_busy),
		.result     (result_out)
	);

endmodule
